@@ rtl/mbaa_pkg.sv @@
// Package for the moment and block average accumulator.
// Holds the sequencer state type, command codes and shared constants.
// No dependencies.
package mbaa_pkg;

  localparam int unsigned MAX_POWERS = 5;
  localparam int unsigned KW = 3;
  localparam int unsigned MASK_W = 6;

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } mbaa_cmd_e;

  typedef enum logic [3:0] {
    STAT_P0   = 4'd0,
    STAT_P1   = 4'd1,
    STAT_P2   = 4'd2,
    STAT_P3   = 4'd3,
    STAT_P4   = 4'd4,
    STAT_MIN  = 4'd5,
    STAT_MAX  = 4'd6,
    STAT_EXP  = 4'd7,
    STAT_PART = 4'd8,
    STAT_LAST = 4'd9
  } mbaa_stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAIN,
    ST_SHIFT,
    ST_LADD,
    ST_LAVG,
    ST_LPOW,
    ST_EMIT
  } mbaa_state_e;

  function automatic logic [63:0] low_mask(input logic [5:0] e);
    low_mask = (64'd1 << e) - 64'd1;
  endfunction

endpackage

@@ rtl/moment_and_block_average_accumulator_unit.sv @@
// Moment and block average accumulator, top level with sequencer.
// Read, clear and no-op go from idle straight to emit. Accumulate runs the main power
// sums, the shift check and, per level, a partial-sum add plus, on a closing block, an
// average and power sums; one item in flight, set by the single shared adder/multiplier.
// Reset (rst_ni low, asynchronous) clears all statistics and the sticky flag.
// Depends on mbaa_pkg, mbaa_arith, mbaa_avg.
module moment_and_block_average_accumulator_unit #(
  parameter int unsigned LEVELS           = 6,
  parameter int unsigned MOMENT_COUNT     = 5,
  parameter int unsigned LOG2_BLOCK_POWER = 1,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] sample_i,
  input  logic [2:0]         level_sel_i,
  input  logic [3:0]         stat_sel_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] read_value_o,
  output logic [5:0]         completed_mask_o,
  output logic               levels_shifted_o,
  output logic               saturated_o
);
  import mbaa_pkg::*;

  localparam int unsigned MAIN_MOMENTS = (MOMENT_COUNT < 2) ? 2 : MOMENT_COUNT;
  localparam int unsigned LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SX  = 64 - SAMPLE_BITS;
  localparam int unsigned MAW = 3 * SAMPLE_BITS;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // statistics
  logic signed [63:0]   ps_q    [MAX_POWERS];
  logic signed [SB-1:0] min_q, max_q, last_q;
  logic [5:0]           lexp_q  [LEVELS];
  logic signed [63:0]   lpart_q [LEVELS];
  logic signed [63:0]   lps_q   [LEVELS][MAX_POWERS];
  logic signed [SB-1:0] lmin_q  [LEVELS];
  logic signed [SB-1:0] lmax_q  [LEVELS];
  logic                 sat_q;

  // sequencer
  mbaa_state_e          state_q, state_d;
  logic signed [SB-1:0] x_q, av_q;
  logic signed [63:0]   prev_q, p_q, rv_q;
  logic [KW-1:0]        k_q;
  logic [LW-1:0]        lvl_q;
  logic [MASK_W-1:0]    mask_q;
  logic                 shifted_q;

  // output register
  logic                 out_valid_q;
  logic signed [63:0]   out_rv_q;
  logic [MASK_W-1:0]    out_mask_q;
  logic                 out_shift_q, out_sat_q;

  logic                 accept, emit, last_lvl, closes, do_shift;
  logic signed [SB-1:0] x_in, av_w;
  logic signed [63:0]   add_a, add_b, add_sum, prod, rd_val, cnt;
  logic                 add_ovf;
  logic signed [SB-1:0] mul_b;
  logic [6:0]           ne;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign emit     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign last_lvl = lvl_q == LW'(LEVELS - 1);
  assign x_in     = sample_i[SB-1:0];
  assign cnt      = ps_q[0];
  assign closes   = (cnt & low_mask(lexp_q[lvl_q])) == 64'd0;
  assign ne       = {1'b0, lexp_q[LEVELS-1]} + 7'(LOG2_BLOCK_POWER);
  assign do_shift = (ne <= 7'd63) && ((cnt & low_mask(ne[5:0])) == 64'd0);

  // shared unit operand selection
  always_comb begin
    add_a = ps_q[k_q];
    add_b = p_q;
    mul_b = x_q;
    case (state_q)
      ST_LADD: begin
        add_a = lpart_q[lvl_q];
        add_b = {{SX{x_q[SB-1]}}, x_q};
      end
      ST_LPOW: begin
        add_a = lps_q[lvl_q][k_q];
        mul_b = av_q;
      end
      default: begin
      end
    endcase
  end

  mbaa_arith #(.MAW(MAW), .SB(SB)) u_arith (
    .a_i(add_a), .b_i(add_b), .ma_i(p_q[MAW-1:0]), .mb_i(mul_b),
    .sum_o(add_sum), .ovf_o(add_ovf), .prod_o(prod)
  );

  mbaa_avg #(.SB(SB)) u_avg (
    .part_i(lpart_q[lvl_q]), .exp_i(lexp_q[lvl_q]), .avg_o(av_w)
  );

  // read mux
  always_comb begin
    rd_val = 64'sd0;
    if (level_sel_i == 3'd0) begin
      case (stat_sel_i)
        STAT_P0, STAT_P1, STAT_P2, STAT_P3, STAT_P4: begin
          if (32'(stat_sel_i) < MAIN_MOMENTS) rd_val = ps_q[stat_sel_i[KW-1:0]];
        end
        STAT_MIN:  rd_val = {{SX{min_q[SB-1]}}, min_q};
        STAT_MAX:  rd_val = {{SX{max_q[SB-1]}}, max_q};
        STAT_LAST: rd_val = {{SX{last_q[SB-1]}}, last_q};
        default:   rd_val = 64'sd0;
      endcase
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (int'(level_sel_i) == l + 1) begin
          case (stat_sel_i)
            STAT_P0, STAT_P1, STAT_P2, STAT_P3, STAT_P4: begin
              if (32'(stat_sel_i) < MOMENT_COUNT) rd_val = lps_q[l][stat_sel_i[KW-1:0]];
            end
            STAT_MIN:  rd_val = {{SX{lmin_q[l][SB-1]}}, lmin_q[l]};
            STAT_MAX:  rd_val = {{SX{lmax_q[l][SB-1]}}, lmax_q[l]};
            STAT_EXP:  rd_val = {58'd0, lexp_q[l]};
            STAT_PART: rd_val = lpart_q[l];
            default:   rd_val = 64'sd0;
          endcase
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (cmd_i == CMD_ACCUM) ? ST_MAIN : ST_EMIT;
        end
      end
      ST_MAIN:  if (k_q == KW'(MAIN_MOMENTS - 1)) state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_LADD;
      ST_LADD: begin
        if (closes) begin
          state_d = ST_LAVG;
        end else if (last_lvl) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_LADD;
        end
      end
      ST_LAVG:  state_d = ST_LPOW;
      ST_LPOW: begin
        if (k_q == KW'(MOMENT_COUNT - 1)) state_d = last_lvl ? ST_EMIT : ST_LADD;
      end
      ST_EMIT:  if (emit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_POWERS; k++) ps_q[k] <= 64'sd0;
      min_q  <= S_MAX;
      max_q  <= S_MIN;
      last_q <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        lexp_q[l]  <= 6'(l * LOG2_BLOCK_POWER);
        lpart_q[l] <= 64'sd0;
        for (int k = 0; k < MAX_POWERS; k++) lps_q[l][k] <= 64'sd0;
        lmin_q[l]  <= S_MAX;
        lmax_q[l]  <= S_MIN;
      end
      sat_q     <= 1'b0;
      x_q       <= '0;
      av_q      <= '0;
      prev_q    <= 64'sd0;
      p_q       <= 64'sd0;
      rv_q      <= 64'sd0;
      k_q       <= '0;
      lvl_q     <= '0;
      mask_q    <= '0;
      shifted_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rv_q      <= 64'sd0;
            mask_q    <= '0;
            shifted_q <= 1'b0;
            k_q       <= '0;
            p_q       <= 64'sd1;
            case (cmd_i)
              CMD_ACCUM: begin
                // capture the sample and the pre-sample sum for a new top level
                x_q    <= x_in;
                prev_q <= ps_q[1];
                last_q <= x_in;
                if (x_in < min_q) min_q <= x_in;
                if (x_in > max_q) max_q <= x_in;
              end
              CMD_READ: rv_q <= rd_val;
              CMD_CLEAR: begin
                for (int k = 0; k < MAX_POWERS; k++) ps_q[k] <= 64'sd0;
                min_q  <= S_MAX;
                max_q  <= S_MIN;
                last_q <= '0;
                for (int l = 0; l < LEVELS; l++) begin
                  lexp_q[l]  <= 6'(l * LOG2_BLOCK_POWER);
                  lpart_q[l] <= 64'sd0;
                  for (int k = 0; k < MAX_POWERS; k++) lps_q[l][k] <= 64'sd0;
                  lmin_q[l]  <= S_MAX;
                  lmax_q[l]  <= S_MIN;
                end
                sat_q <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAIN: begin
          ps_q[k_q] <= add_sum;
          if (add_ovf) sat_q <= 1'b1;
          p_q <= prod;
          k_q <= k_q + KW'(1);
        end
        ST_SHIFT: begin
          lvl_q <= '0;
          if (do_shift) begin
            for (int l = 0; l + 1 < LEVELS; l++) begin
              lexp_q[l]  <= lexp_q[l+1];
              lpart_q[l] <= lpart_q[l+1];
              lps_q[l]   <= lps_q[l+1];
              lmin_q[l]  <= lmin_q[l+1];
              lmax_q[l]  <= lmax_q[l+1];
            end
            lexp_q[LEVELS-1]  <= ne[5:0];
            lpart_q[LEVELS-1] <= prev_q;
            for (int k = 0; k < MAX_POWERS; k++) lps_q[LEVELS-1][k] <= 64'sd0;
            lmin_q[LEVELS-1]  <= S_MAX;
            lmax_q[LEVELS-1]  <= S_MIN;
            shifted_q <= 1'b1;
          end
        end
        ST_LADD: begin
          lpart_q[lvl_q] <= add_sum;
          if (add_ovf) sat_q <= 1'b1;
          if (!closes && !last_lvl) lvl_q <= lvl_q + LW'(1);
        end
        ST_LAVG: begin
          // block closes: average, track extremes, restart the partial sum, set its mask bit
          av_q <= av_w;
          if (av_w < lmin_q[lvl_q]) lmin_q[lvl_q] <= av_w;
          if (av_w > lmax_q[lvl_q]) lmax_q[lvl_q] <= av_w;
          lpart_q[lvl_q] <= 64'sd0;
          for (int i = 0; i < MASK_W; i++) begin
            if (int'(lvl_q) == i) mask_q[i] <= 1'b1;
          end
          p_q <= 64'sd1;
          k_q <= '0;
        end
        ST_LPOW: begin
          lps_q[lvl_q][k_q] <= add_sum;
          if (add_ovf) sat_q <= 1'b1;
          p_q <= prod;
          k_q <= k_q + KW'(1);
          if (k_q == KW'(MOMENT_COUNT - 1) && !last_lvl) lvl_q <= lvl_q + LW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // output register: hold a result until the far side takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rv_q    <= 64'sd0;
      out_mask_q  <= '0;
      out_shift_q <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_rv_q    <= rv_q;
        out_mask_q  <= mask_q;
        out_shift_q <= shifted_q;
        out_sat_q   <= sat_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = out_rv_q;
  assign completed_mask_o = out_mask_q;
  assign levels_shifted_o = out_shift_q;
  assign saturated_o      = out_sat_q;
endmodule

@@ rtl/mbaa_arith.sv @@
// Shared arithmetic unit: one signed multiplier and one saturating 64-bit adder.
// Depends on nothing; widths come from parameters.
module mbaa_arith #(
  parameter int unsigned MAW = 48,
  parameter int unsigned SB  = 16
) (
  input  logic signed [63:0]     a_i,
  input  logic signed [63:0]     b_i,
  input  logic signed [MAW-1:0]  ma_i,
  input  logic signed [SB-1:0]   mb_i,
  output logic signed [63:0]     sum_o,
  output logic                   ovf_o,
  output logic signed [63:0]     prod_o
);
  logic signed [64:0]       wide;
  logic signed [MAW+SB-1:0] full;

  assign wide  = {a_i[63], a_i} + {b_i[63], b_i};
  assign ovf_o = wide[64] != wide[63];
  // clip toward the sign of the true result
  assign sum_o = ovf_o ? (wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : wide[63:0];

  assign full   = ma_i * mb_i;
  assign prod_o = 64'(full);
endmodule

@@ rtl/mbaa_avg.sv @@
// Block average: arithmetic shift of a partial sum, clipped to the sample range.
// Depends on nothing; widths come from parameters.
module mbaa_avg #(
  parameter int unsigned SB = 16
) (
  input  logic signed [63:0]   part_i,
  input  logic [5:0]           exp_i,
  output logic signed [SB-1:0] avg_o
);
  localparam logic signed [63:0] SMAX = 64'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  logic signed [63:0] shifted;

  assign shifted = part_i >>> exp_i;

  always_comb begin
    if (shifted > SMAX) begin
      avg_o = SMAX[SB-1:0];
    end else if (shifted < SMIN) begin
      avg_o = SMIN[SB-1:0];
    end else begin
      avg_o = shifted[SB-1:0];
    end
  end
endmodule

@@ test/tb_moment_and_block_average_accumulator_unit.sv @@
// Testbench for moment_and_block_average_accumulator_unit: directed and random
// sample, read, clear and no-op transfers checked against a built-in predictor.
// Depends on mbaa_pkg and the RTL of the unit.
module tb_moment_and_block_average_accumulator_unit;
  import mbaa_pkg::*;

  localparam int NLEV = 6;
  localparam int NPOW = 5;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;

  // One input transfer plus driver hints: the idle phase and whether the
  // sender must hold off until all outstanding results have come back.
  typedef struct {
    mbaa_cmd_e          cmd;
    logic signed [15:0] smp;
    logic [2:0]         lev;
    logic [3:0]         st;
    bit                 drain;
    int                 phase;
  } stim_t;

  typedef struct {
    logic signed [63:0] rv;
    logic [5:0]         mask;
    logic               shifted;
    logic               sat;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic signed [15:0] sample_i;
  logic [2:0]         level_sel_i;
  logic [3:0]         stat_sel_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [63:0] read_value_o;
  logic [5:0]         completed_mask_o;
  logic               levels_shifted_o;
  logic               saturated_o;

  moment_and_block_average_accumulator_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .sample_i        (sample_i),
    .level_sel_i     (level_sel_i),
    .stat_sel_i      (stat_sel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_value_o    (read_value_o),
    .completed_mask_o(completed_mask_o),
    .levels_shifted_o(levels_shifted_o),
    .saturated_o     (saturated_o)
  );

  stim_t   pending_q[$];
  result_t expected_q[$];
  int      err_cnt = 0;
  bit      in_took = 0;
  int      cur_phase = 0;

  // Predictor state: main store, block levels, sticky saturation flag.
  longint      main_sum[NPOW];
  longint      main_min, main_max, main_last;
  int unsigned lvl_exp[NLEV];
  longint      lvl_part[NLEV];
  longint      lvl_sum[NLEV][NPOW];
  longint      lvl_min[NLEV], lvl_max[NLEV];
  bit          sat_flag;

  // Signed 64-bit add that clips at the limits and raises the sticky flag.
  function automatic longint sat_add(longint a, longint b);
    longint r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat_flag = 1'b1;
      r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return r;
  endfunction

  function automatic logic [63:0] ones_below(int unsigned e);
    return (e >= 64) ? '1 : ((64'd1 << e) - 64'd1);
  endfunction

  task automatic clear_level(int l, int unsigned e);
    lvl_exp[l]  = e & 63;
    lvl_part[l] = 0;
    for (int k = 0; k < NPOW; k++) lvl_sum[l][k] = 0;
    lvl_min[l] = SMAX;
    lvl_max[l] = SMIN;
  endtask

  task automatic clear_stats();
    for (int k = 0; k < NPOW; k++) main_sum[k] = 0;
    main_min  = SMAX;
    main_max  = SMIN;
    main_last = 0;
    for (int l = 0; l < NLEV; l++) clear_level(l, l);
    sat_flag = 1'b0;
  endtask

  // Add x^0..x^4 into the main store (l < 0) or into level l.
  task automatic add_powers(int l, longint x);
    longint p;
    p = 1;
    for (int k = 0; k < NPOW; k++) begin
      if (l < 0) main_sum[k] = sat_add(main_sum[k], p);
      else lvl_sum[l][k] = sat_add(lvl_sum[l][k], p);
      p = p * x;
    end
  endtask

  function automatic longint stat_value(int unsigned lev, logic [3:0] st);
    int l;
    if (lev == 0) begin
      if (st <= STAT_P4) return main_sum[st];
      if (st == STAT_MIN) return main_min;
      if (st == STAT_MAX) return main_max;
      if (st == STAT_LAST) return main_last;
      return 0;
    end
    if (lev > NLEV) return 0;
    l = lev - 1;
    if (st <= STAT_P4) return lvl_sum[l][st];
    if (st == STAT_MIN) return lvl_min[l];
    if (st == STAT_MAX) return lvl_max[l];
    if (st == STAT_EXP) return longint'(lvl_exp[l]);
    if (st == STAT_PART) return lvl_part[l];
    return 0;
  endfunction

  task automatic predict_moments(stim_t s, output result_t r);
    longint      x, prev, av;
    logic [63:0] cnt;
    int unsigned ne;
    r = '{rv: 0, mask: 0, shifted: 0, sat: 0};
    if (s.cmd == CMD_ACCUM) begin
      x = s.smp;
      prev = main_sum[1];
      main_last = x;
      add_powers(-1, x);
      if (x < main_min) main_min = x;
      if (x > main_max) main_max = x;
      cnt = main_sum[0];
      // Drop the smallest level once the count hits the next doubling.
      ne = lvl_exp[NLEV-1] + 1;
      if (ne <= 63 && (cnt & ones_below(ne)) == 0) begin
        for (int l = 0; l + 1 < NLEV; l++) begin
          lvl_exp[l]  = lvl_exp[l+1];
          lvl_part[l] = lvl_part[l+1];
          for (int k = 0; k < NPOW; k++) lvl_sum[l][k] = lvl_sum[l+1][k];
          lvl_min[l] = lvl_min[l+1];
          lvl_max[l] = lvl_max[l+1];
        end
        clear_level(NLEV-1, ne);
        lvl_part[NLEV-1] = prev;
        r.shifted = 1'b1;
      end
      for (int l = 0; l < NLEV; l++) begin
        lvl_part[l] = sat_add(lvl_part[l], x);
        if ((cnt & ones_below(lvl_exp[l])) == 0) begin
          av = lvl_part[l] >>> lvl_exp[l];
          if (av > SMAX) av = SMAX;
          if (av < SMIN) av = SMIN;
          add_powers(l, av);
          if (av < lvl_min[l]) lvl_min[l] = av;
          if (av > lvl_max[l]) lvl_max[l] = av;
          lvl_part[l] = 0;
          r.mask[l] = 1'b1;
        end
      end
    end else if (s.cmd == CMD_READ) begin
      r.rv = stat_value(s.lev, s.st);
    end else if (s.cmd == CMD_CLEAR) begin
      clear_stats();
    end
    r.sat = sat_flag;
  endtask

  function automatic stim_t make_item(mbaa_cmd_e c, int v, int lev, int st, int ph);
    stim_t s;
    s.cmd = c;
    s.smp = 16'(v);
    s.lev = 3'(lev);
    s.st = 4'(st);
    s.drain = 0;
    s.phase = ph;
    return s;
  endfunction

  // Append one stimulus item to the pending list.
  task automatic add_item(stim_t s);
    pending_q.insert(pending_q.size(), s);
  endtask

  // Mostly sample runs with random content, some reads, rare clears and no-ops.
  function automatic stim_t random_item(int ph);
    int unsigned pick, mag;
    mbaa_cmd_e   c;
    int          v;
    pick = $urandom_range(999);
    if (pick < 5) c = CMD_CLEAR;
    else if (pick < 25) c = CMD_NOP;
    else if (pick < 280) c = CMD_READ;
    else c = CMD_ACCUM;
    mag = $urandom_range(9);
    if (mag < 5) v = $signed($urandom_range(511)) - 256;
    else if (mag < 8) v = $signed({16'd0, 16'($urandom)}) - 32768;
    else if (mag == 8) v = SMAX;
    else v = SMIN;
    return make_item(c, v, $urandom_range(7), $urandom_range(15), ph);
  endfunction

  // Clock, reset and stimulus list.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_NOP;
    sample_i = '0;
    level_sel_i = '0;
    stat_sel_i = '0;
    out_stall_i = 1'b0;
    clear_stats();

    // Directed: sample extremes, every command, out-of-range selectors.
    add_item(make_item(CMD_READ, 0, 0, STAT_MIN, 2));
    add_item(make_item(CMD_READ, 0, 1, STAT_EXP, 2));
    add_item(make_item(CMD_ACCUM, SMAX, 0, 0, 2));
    add_item(make_item(CMD_ACCUM, SMIN, 7, 15, 2));
    add_item(make_item(CMD_ACCUM, 0, 0, 0, 2));
    add_item(make_item(CMD_ACCUM, -1, 0, 0, 2));
    add_item(make_item(CMD_ACCUM, 1, 0, 0, 2));
    add_item(make_item(CMD_NOP, -1, 7, 15, 2));
    add_item(make_item(CMD_READ, 0, 0, STAT_P4, 2));
    add_item(make_item(CMD_READ, 0, 0, STAT_LAST, 2));
    add_item(make_item(CMD_READ, 0, 0, STAT_PART, 2));
    add_item(make_item(CMD_READ, 0, 2, STAT_PART, 2));
    add_item(make_item(CMD_READ, 0, 1, STAT_LAST, 2));
    add_item(make_item(CMD_READ, 0, 7, STAT_P1, 2));
    add_item(make_item(CMD_READ, 0, 3, 15, 2));
    // Drive the fourth power sum into saturation.
    for (int i = 0; i < 8; i++) add_item(make_item(CMD_ACCUM, SMIN, 0, 0, 2));
    add_item(make_item(CMD_READ, 0, 0, STAT_P4, 2));
    add_item(make_item(CMD_CLEAR, SMAX, 7, 15, 2));

    // Random: receiver-heavy stalling, sender-heavy idling, then no idling or stalling.
    for (int i = 0; i < 1200; i++) begin
      stim_t s;
      s = random_item(i / 400);
      if (i % 400 == 0 || $urandom_range(199) == 0) s.drain = 1;
      add_item(s);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid_i);
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Predict on every accepted input transfer.
  always @(posedge clk_i) begin
    result_t r;
    stim_t   s;
    in_took <= in_valid_i && !in_stall_o && rst_ni;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      s = make_item(mbaa_cmd_e'(cmd_i), sample_i, level_sel_i, stat_sel_i, 0);
      predict_moments(s, r);
      expected_q.insert(expected_q.size(), r);
    end
  end

  // Driver: hold a stalled transfer, otherwise advance or idle.
  always @(negedge clk_i) begin
    int  idle_pct;
    bit  go;
    if (rst_ni && (!in_valid_i || in_took)) begin
      go = 1'b0;
      if (pending_q.size() != 0) begin
        cur_phase = pending_q[0].phase;
        idle_pct = (cur_phase == 0) ? 26 : (cur_phase == 1) ? 75 : 0;
        go = !(pending_q[0].drain && expected_q.size() != 0) &&
             ($urandom_range(99) >= idle_pct);
      end
      if (go) begin
        cmd_i       <= pending_q[0].cmd;
        sample_i    <= pending_q[0].smp;
        level_sel_i <= pending_q[0].lev;
        stat_sel_i  <= pending_q[0].st;
        void'(pending_q.pop_front());
      end
      in_valid_i <= go;
    end
  end

  // Receiver stall, per phase.
  always @(negedge clk_i) begin
    int stall_pct;
    stall_pct = (cur_phase == 0) ? 75 : (cur_phase == 1) ? 26 : 0;
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual read_value %0d", $time, read_value_o);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (read_value_o !== e.rv) begin
          $display("%0t: read_value expected %0d actual %0d", $time, e.rv, read_value_o);
          err_cnt++;
        end
        if (completed_mask_o !== e.mask) begin
          $display("%0t: completed_mask expected %b actual %b", $time, e.mask,
                   completed_mask_o);
          err_cnt++;
        end
        if (levels_shifted_o !== e.shifted) begin
          $display("%0t: levels_shifted expected %b actual %b", $time, e.shifted,
                   levels_shifted_o);
          err_cnt++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated_o);
          err_cnt++;
        end
      end
    end
  end

endmodule
